/* hw/rtl/rase_pkg.sv */
package rase_pkg;

    localparam int ANGLE_W  = 15;
    localparam int POLE_W   = 4;
    localparam int LIMIT_W  = 12;
    localparam int GAIN_W   = 17;
    localparam int SPEED_W  = 13;
    localparam int ACC_W    = 30;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [ANGLE_W-1:0] TURN      = 15'd23040;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 15'd11520;
    localparam logic [GAIN_W-1:0]  Q16_ONE   = 17'd65536;
    localparam int                 OUT_MAX   = 4095;

    localparam logic [ANGLE_W-1:0] ZERO_OFFSET_RST = 15'd11840;
    localparam logic [POLE_W-1:0]  ELEC_RATIO_RST  = 4'd2;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 12'd2560;
    localparam logic [GAIN_W-1:0]  FILTER_GAIN_RST = 17'd1311;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_OFFSET = 2'd0,
        CFG_ELEC_RATIO  = 2'd1,
        CFG_SPEED_LIMIT = 2'd2,
        CFG_FILTER_GAIN = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANGLE,
        S_ELEC,
        S_SPEED,
        S_MULT,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic angle;
        logic elec_step;
        logic speed;
        logic mult;
        logic acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
    } t_status;

endpackage

/* hw/rtl/rase_ctrl.sv */
module rase_ctrl
    import rase_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_ANGLE;
            S_ANGLE: n_state = S_ELEC;
            S_ELEC:  if (i_status.cnt_zero) n_state = S_SPEED;
            S_SPEED: n_state = S_MULT;
            S_MULT:  n_state = S_ACC;
            S_ACC:   n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_ANGLE: o_cmd.angle = 1'b1;
            S_ELEC:  o_cmd.elec_step = !i_status.cnt_zero;
            S_SPEED: o_cmd.speed = 1'b1;
            S_MULT:  o_cmd.mult = 1'b1;
            S_ACC:   o_cmd.acc = 1'b1;
            S_OUT:   o_cmd.out_load = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* hw/rtl/rase_dp.sv */
module rase_dp
    import rase_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic [ANGLE_W-1:0]        i_sensed_angle,
    input  logic [ANGLE_W-1:0]        i_zero_offset,
    input  logic [POLE_W-1:0]         i_elec_ratio,
    input  logic [LIMIT_W-1:0]        i_speed_limit,
    input  logic [GAIN_W-1:0]         i_filter_gain,
    output logic [ANGLE_W-1:0]        o_mech_angle,
    output logic [ANGLE_W-1:0]        o_elec_angle,
    output logic signed [SPEED_W-1:0] o_speed_filtered
);

    logic [ANGLE_W-1:0]        r_sensed;
    logic [ANGLE_W-1:0]        r_mech;
    logic [ANGLE_W-1:0]        r_elec;
    logic [POLE_W-1:0]         r_cnt;
    logic [ANGLE_W-1:0]        r_last;
    logic                      r_first;
    logic signed [SPEED_W-1:0] r_raw;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [47:0]        r_p1;
    logic signed [30:0]        r_p2;
    logic [ANGLE_W-1:0]        r_out_mech;
    logic [ANGLE_W-1:0]        r_out_elec;
    logic signed [SPEED_W-1:0] r_out_speed;

    logic [ANGLE_W-1:0]        w_sens;
    logic [ANGLE_W-1:0]        w_zero;
    logic [ANGLE_W:0]          w_mech_ext;
    logic [ANGLE_W:0]          w_elec_sum;
    logic [ANGLE_W-1:0]        w_elec_next;
    logic [ANGLE_W-1:0]        w_last;
    logic signed [ANGLE_W:0]   w_diff;
    logic signed [ANGLE_W:0]   w_wrap;
    logic signed [20:0]        w_raw;
    logic signed [20:0]        w_lim;
    logic signed [SPEED_W-1:0] w_raw_clamp;
    logic [GAIN_W-1:0]         w_gain;
    logic [GAIN_W-1:0]         w_one_minus;
    logic signed [31:0]        w_p1_shift;
    logic signed [31:0]        w_acc_sum;
    logic signed [ACC_W:0]     w_round;
    logic signed [14:0]        w_sf;
    logic signed [SPEED_W-1:0] w_sf_clamp;

    // one compare-subtract brings any 15-bit angle into range
    assign w_sens = (r_sensed >= TURN) ? r_sensed - TURN : r_sensed;
    assign w_zero = (i_zero_offset >= TURN) ? i_zero_offset - TURN : i_zero_offset;
    assign w_mech_ext = (w_sens >= w_zero) ? {1'b0, w_sens} - {1'b0, w_zero}
                                           : {1'b0, w_sens} + {1'b0, TURN} - {1'b0, w_zero};

    // electrical angle by repeated modular add, one pole pair per cycle
    assign w_elec_sum  = {1'b0, r_elec} + {1'b0, r_mech};
    assign w_elec_next = (w_elec_sum >= {1'b0, TURN}) ? w_elec_sum[ANGLE_W-1:0] - TURN
                                                      : w_elec_sum[ANGLE_W-1:0];
    assign o_status.cnt_zero = (r_cnt == '0);

    assign w_last = r_first ? r_mech : r_last;
    assign w_diff = $signed({1'b0, r_mech}) - $signed({1'b0, w_last});
    always_comb begin
        w_wrap = w_diff;
        if (w_diff >= $signed({1'b0, HALF_TURN})) begin
            w_wrap = w_diff - $signed({1'b0, TURN});
        end else if (w_diff <= -$signed({1'b0, HALF_TURN})) begin
            w_wrap = w_diff + $signed({1'b0, TURN});
        end
    end

    // times 20 as shift and add
    assign w_raw = ($signed({{5{w_wrap[ANGLE_W]}}, w_wrap}) <<< 4)
                 + ($signed({{5{w_wrap[ANGLE_W]}}, w_wrap}) <<< 2);
    assign w_lim = $signed({9'd0, i_speed_limit});
    always_comb begin
        if (w_raw > w_lim) begin
            w_raw_clamp = w_lim[SPEED_W-1:0];
        end else if (w_raw < -w_lim) begin
            w_raw_clamp = SPEED_W'(-w_lim);
        end else begin
            w_raw_clamp = w_raw[SPEED_W-1:0];
        end
    end

    assign w_gain      = (i_filter_gain > Q16_ONE) ? Q16_ONE : i_filter_gain;
    assign w_one_minus = Q16_ONE - w_gain;

    // floor((acc*(1-g) + raw*g*2^16) / 2^16) = (acc*(1-g) >>> 16) + raw*g
    assign w_p1_shift = r_p1[47:16];
    assign w_acc_sum  = w_p1_shift + {{1{r_p2[30]}}, r_p2};

    assign w_round = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(32768);
    assign w_sf    = w_round[ACC_W:16];
    always_comb begin
        if (w_sf > 15'sd4095) begin
            w_sf_clamp = SPEED_W'(OUT_MAX);
        end else if (w_sf < -15'sd4095) begin
            w_sf_clamp = -SPEED_W'(OUT_MAX);
        end else begin
            w_sf_clamp = w_sf[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_acc   <= '0;
            r_first <= 1'b1;
        end else begin
            if (i_cmd.speed && r_first) begin
                r_acc <= '0;
            end
            if (i_cmd.acc) begin
                r_acc   <= w_acc_sum[ACC_W-1:0];
                r_last  <= r_mech;
                r_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sensed <= i_sensed_angle;
        end
        if (i_cmd.angle) begin
            r_mech <= w_mech_ext[ANGLE_W-1:0];
            r_elec <= '0;
            r_cnt  <= i_elec_ratio;
        end
        if (i_cmd.elec_step) begin
            r_elec <= w_elec_next;
            r_cnt  <= r_cnt - 1'b1;
        end
        if (i_cmd.speed) begin
            r_raw <= w_raw_clamp;
        end
        if (i_cmd.mult) begin
            r_p1 <= r_acc * $signed({1'b0, w_one_minus});
            r_p2 <= r_raw * $signed({1'b0, w_gain});
        end
        if (i_cmd.out_load) begin
            r_out_mech  <= r_mech;
            r_out_elec  <= r_elec;
            r_out_speed <= w_sf_clamp;
        end
    end

    assign o_mech_angle     = r_out_mech;
    assign o_elec_angle     = r_out_elec;
    assign o_speed_filtered = r_out_speed;

endmodule

/* hw/rtl/rotor_angle_speed_estimator.sv */
// rotor angle and speed estimator
// input channel: i_valid / o_ready, one beat carries i_sensed_angle (1/64 deg)
// output channel: o_valid / i_ready, one beat carries o_mech_angle, o_elec_angle
//   and o_speed_filtered (1/64 kdeg/s, two's complement)
// config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index selects
//   zero offset, pole pair count, speed limit or filter gain, i_cfg_data is the value
// one item at a time; an input beat passes through the angle, electrical angle,
//   speed, multiply, accumulate and output states, the electrical angle sequencer
//   adding the mechanical angle once per pole pair; the next beat is taken in the
//   cycle after the result loads
// the output register holds a finished result while the next beat is accepted;
//   if the receiver stalls, the following item waits in its last step until the
//   output register frees
// reset restores the default registers, clears the filter and marks the next
//   beat as the first sample, which gives zero speed
module rotor_angle_speed_estimator
    import rase_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ANGLE_W-1:0]        i_sensed_angle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ANGLE_W-1:0]        o_mech_angle,
    output logic [ANGLE_W-1:0]        o_elec_angle,
    output logic signed [SPEED_W-1:0] o_speed_filtered,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    logic [ANGLE_W-1:0] r_zero_offset;
    logic [POLE_W-1:0]  r_elec_ratio;
    logic [LIMIT_W-1:0] r_speed_limit;
    logic [GAIN_W-1:0]  r_filter_gain;
    t_cmd               w_cmd;
    t_status            w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= ZERO_OFFSET_RST;
            r_elec_ratio  <= ELEC_RATIO_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
            r_filter_gain <= FILTER_GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ZERO_OFFSET: r_zero_offset <= i_cfg_data[ANGLE_W-1:0];
                CFG_ELEC_RATIO:  r_elec_ratio  <= i_cfg_data[POLE_W-1:0];
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_FILTER_GAIN: r_filter_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    rase_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rase_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_sensed_angle   (i_sensed_angle),
        .i_zero_offset    (r_zero_offset),
        .i_elec_ratio     (r_elec_ratio),
        .i_speed_limit    (r_speed_limit),
        .i_filter_gain    (r_filter_gain),
        .o_mech_angle     (o_mech_angle),
        .o_elec_angle     (o_elec_angle),
        .o_speed_filtered (o_speed_filtered)
    );

endmodule
